### rtl/hall_commutation_tracker_defines.svh
// Assertion macros shared by the hall_commutation_tracker verification code.
// Has no dependencies; each macro expects clk_i in scope, and all but HCT_ASSERT_ALWAYS also rst_ni.
`ifndef HALL_COMMUTATION_TRACKER_DEFINES_SVH
`define HALL_COMMUTATION_TRACKER_DEFINES_SVH

// Next-cycle implication, disabled while reset is asserted.
`define HCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hall_commutation_tracker check failed");

// Same-cycle implication, disabled while reset is asserted.
`define HCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hall_commutation_tracker check failed");

// Next-cycle implication that is also checked during reset.
`define HCT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("hall_commutation_tracker check failed");

`endif

### rtl/hct_pkg.sv
// Types, codes and constant tables of the Hall commutation tracker.
// Has no dependencies; used by every module of the block.
package hct_pkg;

  localparam int MOTORS = 2;
  localparam int MOTOR_W = 1;
  localparam int POS_W = 32;
  localparam int TBL_W = 48;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_AW = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int IN_DATA_W = 16;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  localparam logic [1:0] KIND_EDGE = 2'd0;
  localparam logic [1:0] KIND_FLAGS = 2'd1;
  localparam logic [1:0] KIND_RESYNC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_M0_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M0_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M1_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M1_HIGH = 2'd3;

  localparam logic [1:0] FLAG_GLITCH = 2'b01;
  localparam logic [1:0] FLAG_TABLE = 2'b10;

  localparam logic [2:0] FWD_NEXT [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
  localparam logic [2:0] REV_NEXT [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_FLAGS,
    OP_RESYNC,
    OP_NONE
  } hct_op_e;

  typedef struct packed {
    hct_op_e              op;
    logic [MOTOR_W-1:0]   motor;
    logic [2:0]           s1;
    logic [2:0]           s2;
    logic [2:0]           s3;
    logic                 stable;
    logic [1:0]           flags;
  } hct_cmd_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic               drive;
    logic [2:0]         hall;
    logic [5:0]         gate_low;
    logic [5:0]         gate_high;
    logic [POS_W-1:0]   position;
    logic [1:0]         errors;
  } hct_res_t;

endpackage

### rtl/hct_front.sv
// Front end of the tracker: unpacks an input item and classifies its kind.
// Depends on hct_pkg; feeds hct_queue.
module hct_front import hct_pkg::*; (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tuser: kind[1:0], motor[2]
  input  logic [IN_USER_W-1:0] s_axis_tuser_i,
  // tdata: first_sample[2:0], second_sample[5:3], third_sample[8:6], flag_value[10:9]
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic                 q_ready_i,
  output logic                 q_push_o,
  output hct_cmd_t             q_cmd_o
);

  hct_op_e op;

  always_comb begin
    unique case (s_axis_tuser_i[1:0])
      KIND_EDGE:   op = OP_EDGE;
      KIND_FLAGS:  op = OP_FLAGS;
      KIND_RESYNC: op = OP_RESYNC;
      default:     op = OP_NONE;
    endcase
  end

  always_comb begin
    q_cmd_o.op     = op;
    q_cmd_o.motor  = s_axis_tuser_i[2];
    q_cmd_o.s1     = s_axis_tdata_i[2:0];
    q_cmd_o.s2     = s_axis_tdata_i[5:3];
    q_cmd_o.s3     = s_axis_tdata_i[8:6];
    q_cmd_o.stable = s_axis_tdata_i[2:0] == s_axis_tdata_i[5:3];
    q_cmd_o.flags  = s_axis_tdata_i[10:9];
  end

  assign s_axis_tready_o = q_ready_i;
  assign q_push_o = s_axis_tvalid_i && q_ready_i;

endmodule

### rtl/hct_queue.sv
// Short command queue between the front end and the execution stage.
// Depends on hct_pkg.
module hct_queue import hct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hct_cmd_t cmd_i,
  output logic     ready_o,
  output logic     valid_o,
  input  logic     pop_i,
  output hct_cmd_t cmd_o
);

  hct_cmd_t mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0] count_q, count_d;

  assign ready_o = count_q < QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d = count_q + (QUEUE_AW+1)'(push_i) - (QUEUE_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/hct_back.sv
// Execution stage: per-motor Hall state, position count, flags and gate masks,
// the commutation table registers and the output register. Depends on hct_pkg.
module hct_back import hct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TBL_W-1:0]      cfg_wdata_i,
  input  logic                  q_valid_i,
  input  hct_cmd_t              q_cmd_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hct_res_t              out_res_o
);

  logic [TBL_W-1:0] tbl_q [MOTORS][2];
  logic [2:0] last_q [MOTORS];
  logic [2:0] cur_q [MOTORS];
  logic [POS_W-1:0] step_q [MOTORS];
  logic [1:0] err_q [MOTORS];
  logic [11:0] gate_q [MOTORS];
  logic out_valid_q;
  hct_res_t out_q, out_d;

  logic [MOTOR_W-1:0] m;
  logic [2:0] prev, fwd, rev, last_d, cur_d;
  logic [POS_W-1:0] step_d;
  logic [1:0] err_d;
  logic [11:0] gate_d, entry;
  logic [TBL_W-1:0] word;
  logic drive;

  assign m = q_cmd_i.motor;
  assign prev = last_q[m];
  assign fwd = FWD_NEXT[prev];
  assign rev = REV_NEXT[prev];
  assign word = tbl_q[m][q_cmd_i.s2[2]];

  always_comb begin
    case (q_cmd_i.s2[1:0])
      2'd0:    entry = word[11:0];
      2'd1:    entry = word[23:12];
      2'd2:    entry = word[35:24];
      default: entry = word[47:36];
    endcase
  end

  always_comb begin
    last_d = last_q[m];
    cur_d = cur_q[m];
    step_d = step_q[m];
    err_d = err_q[m];
    gate_d = gate_q[m];
    drive = 1'b0;
    unique case (q_cmd_i.op)
      OP_EDGE: begin
        if (q_cmd_i.s1 == fwd || q_cmd_i.s1 == rev) begin
          cur_d = q_cmd_i.s2;
          if (q_cmd_i.stable) begin
            gate_d = entry;
            drive = 1'b1;
            last_d = q_cmd_i.s2;
            if (q_cmd_i.s2 == fwd) begin
              step_d = step_q[m] + POS_W'(1);
            end else begin
              step_d = step_q[m] - POS_W'(1);
            end
          end else begin
            err_d = err_d | FLAG_GLITCH;
          end
        end else begin
          err_d = err_d | FLAG_TABLE;
        end
        if (q_cmd_i.s3 != cur_d) begin
          err_d = err_d | FLAG_GLITCH;
        end
      end
      OP_FLAGS:  err_d = q_cmd_i.flags;
      OP_RESYNC: last_d = q_cmd_i.s1;
      default:   ;
    endcase
  end

  always_comb begin
    out_d.motor = m;
    out_d.drive = drive;
    out_d.hall = cur_d;
    out_d.gate_low = gate_d[5:0];
    out_d.gate_high = gate_d[11:6];
    out_d.position = step_d;
    out_d.errors = err_d;
  end

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        last_q[i] <= '0;
        cur_q[i] <= '0;
        step_q[i] <= '0;
        err_q[i] <= '0;
        gate_q[i] <= '0;
        tbl_q[i][0] <= '0;
        tbl_q[i][1] <= '0;
      end
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        last_q[m] <= last_d;
        cur_q[m] <= cur_d;
        step_q[m] <= step_d;
        err_q[m] <= err_d;
        gate_q[m] <= gate_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_M0_LOW:  tbl_q[0][0] <= cfg_wdata_i;
          CFG_M0_HIGH: tbl_q[0][1] <= cfg_wdata_i;
          CFG_M1_LOW:  tbl_q[1][0] <= cfg_wdata_i;
          CFG_M1_HIGH: tbl_q[1][1] <= cfg_wdata_i;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

### rtl/hall_commutation_tracker.sv
// Top level of the two-motor six-step Hall commutation tracker.
// Depends on hct_pkg, hct_front, hct_queue and hct_back.
//
// Items enter on the s_axis channel: tuser carries the kind and the motor,
// tdata the three Hall reads and the flag value. Kind 0 is a Hall edge that
// checks the reads against the last valid state, loads gate masks from the
// motor's commutation table and steps the position count; kind 1 overwrites
// the sticky error flags; kind 2 resyncs the last valid state; kind 3 only
// reports. Every item gives exactly one result on the m_axis channel, in order.
// The user writes the commutation tables through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while no item is in flight; the block does not enforce it.
// An accepted item passes through the queue and the output register before
// it is offered as a result. One item per cycle is sustained while the
// receiver takes every result; the state update in the execution stage
// sets that rate.
// Reset clears all motor state, the tables and both channels' control.
// When the receiver stalls, the result holds in the output register and a
// two-entry queue keeps taking items until it fills, then s_axis_tready_o
// drops.
module hall_commutation_tracker import hct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TBL_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tuser: kind[1:0], motor[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // tdata: first_sample[2:0], second_sample[5:3], third_sample[8:6], flag_value[10:9]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tuser: out_motor[0], drive_update[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  // tdata: hall_state[2:0], gate_low_mask[8:3], gate_high_mask[14:9],
  // position[46:15], error_flags[48:47]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic q_push, q_ready, q_valid, q_pop;
  hct_cmd_t push_cmd, head_cmd;
  hct_res_t res;

  hct_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  hct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd)
  );

  hct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tuser_o = {res.drive, res.motor};
  assign m_axis_tdata_o = {7'd0, res.errors, res.position, res.gate_high, res.gate_low,
                           res.hall};

endmodule

### rtl/hct_checker.sv
// Port-level checks of the Hall commutation tracker, bound to the top level.
// Depends on hct_pkg and hall_commutation_tracker_defines.svh.
`include "hall_commutation_tracker_defines.svh"

module hct_checker import hct_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic out_stall;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // A stalled result stays offered and unchanged.
  `HCT_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o)
  `HCT_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // The input side only backs up behind a waiting result.
  `HCT_ASSERT_NOW(a_full_needs_result, !s_axis_tready_o, m_axis_tvalid_o)
  // No result appears straight out of reset.
  `HCT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni, !m_axis_tvalid_o)

endmodule

bind hall_commutation_tracker hct_checker u_hct_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for hall_commutation_tracker: directed and random items per motor.
// Uses hct_pkg for port widths, register indexes, item kinds and flag bits; needs only the RTL.
// A local commutation predictor checks every result against a queue of expected results.
module testbench;
  import hct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int NUM_ROWS = 23;

  localparam logic [2:0] HALL_FWD [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
  localparam logic [2:0] HALL_REV [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};

  typedef struct packed {
    hct_op_e    kind;
    logic       motor;
    logic [2:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    logic [1:0] fv;
  } hall_item_t;

  typedef struct packed {
    logic               motor;
    logic [2:0]         hall;
    logic               drive;
    logic [5:0]         gate_low;
    logic [5:0]         gate_high;
    logic signed [31:0] position;
    logic [1:0]         errors;
  } hall_result_t;

  typedef struct packed {
    hall_item_t   item;
    logic         typed;
    hall_result_t res;
  } dir_row_t;

  localparam hall_result_t NO_RESULT = '0;

  // Rows marked typed carry the expected result; the tables hold all ones here.
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{'{OP_NONE,   1'b0, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 6'd0, 6'd0, 32'sd0, 2'd0}},
    '{'{OP_FLAGS,  1'b1, 3'd0, 3'd0, 3'd0, 2'd3}, 1'b1,
      '{1'b1, 3'd0, 1'b0, 6'd0, 6'd0, 32'sd0, 2'd3}},
    '{'{OP_FLAGS,  1'b1, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b1,
      '{1'b1, 3'd0, 1'b0, 6'd0, 6'd0, 32'sd0, 2'd0}},
    '{'{OP_EDGE,   1'b0, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b1,
      '{1'b0, 3'd0, 1'b1, 6'd63, 6'd63, 32'sd1, 2'd0}},
    '{'{OP_EDGE,   1'b0, 3'd7, 3'd7, 3'd7, 2'd0}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 6'd63, 6'd63, 32'sd1, 2'd3}},
    '{'{OP_FLAGS,  1'b0, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 6'd63, 6'd63, 32'sd1, 2'd0}},
    '{'{OP_RESYNC, 1'b0, 3'd1, 3'd0, 3'd0, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd5, 3'd5, 3'd5, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd4, 3'd4, 3'd4, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd5, 3'd5, 3'd5, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd4, 3'd6, 3'd6, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd1, 3'd1, 3'd0, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_FLAGS,  1'b0, 3'd0, 3'd0, 3'd0, 2'd2}, 1'b0, NO_RESULT},
    '{'{OP_RESYNC, 1'b0, 3'd7, 3'd0, 3'd0, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b0, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_RESYNC, 1'b1, 3'd6, 3'd0, 3'd0, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b1, 3'd4, 3'd4, 3'd4, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b1, 3'd5, 3'd5, 3'd5, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b1, 3'd3, 3'd3, 3'd5, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b1, 3'd1, 3'd1, 3'd1, 2'd0}, 1'b0, NO_RESULT},
    '{'{OP_NONE,   1'b1, 3'd7, 3'd7, 3'd7, 2'd3}, 1'b0, NO_RESULT},
    '{'{OP_RESYNC, 1'b1, 3'd0, 3'd7, 3'd7, 2'd3}, 1'b0, NO_RESULT},
    '{'{OP_EDGE,   1'b1, 3'd0, 3'd0, 3'd0, 2'd0}, 1'b0, NO_RESULT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [TBL_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_USER_W-1:0]  s_axis_tuser_i;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [TBL_W-1:0] comm_words [4];
  logic [2:0]       last_hall [2];
  logic [2:0]       cur_hall [2];
  logic [31:0]      steps [2];
  logic [1:0]       err_flags [2];
  logic [11:0]      gate_mask [2];

  hall_result_t pending_results [$];
  hall_result_t observed;
  hall_result_t wanted;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           send_idle = 1'b0;
  bit           recv_idle = 1'b0;

  hall_commutation_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic hall_result_t commutate(hall_item_t it);
    logic [2:0]   prev;
    logic [47:0]  word;
    logic         m;
    hall_result_t r;
    m = it.motor;
    r = '0;
    case (it.kind)
      OP_EDGE: begin
        prev = last_hall[m];
        if (it.s1 == HALL_FWD[prev] || it.s1 == HALL_REV[prev]) begin
          cur_hall[m] = it.s2;
          if (it.s2 == it.s1) begin
            word = comm_words[{m, it.s2[2]}];
            gate_mask[m] = word[12*it.s2[1:0] +: 12];
            r.drive = 1'b1;
            if (it.s2 == HALL_FWD[prev]) begin
              steps[m] = steps[m] + 32'd1;
            end else if (it.s2 == HALL_REV[prev]) begin
              steps[m] = steps[m] - 32'd1;
            end
            last_hall[m] = it.s2;
          end else begin
            err_flags[m] = err_flags[m] | FLAG_GLITCH;
          end
        end else begin
          err_flags[m] = err_flags[m] | FLAG_TABLE;
        end
        if (it.s3 != cur_hall[m]) err_flags[m] = err_flags[m] | FLAG_GLITCH;
      end
      OP_FLAGS: err_flags[m] = it.fv;
      OP_RESYNC: last_hall[m] = it.s1;
      default: ;
    endcase
    r.motor = m;
    r.hall = cur_hall[m];
    r.gate_low = gate_mask[m][5:0];
    r.gate_high = gate_mask[m][11:6];
    r.position = steps[m];
    r.errors = err_flags[m];
    return r;
  endfunction

  // Mostly clean neighbor steps with random direction, plus noise and other kinds.
  function automatic hall_item_t next_item();
    hall_item_t  it;
    int unsigned roll;
    logic [2:0]  prev;
    it.kind = OP_EDGE;
    it.motor = 1'($urandom_range(0, 1));
    it.s1 = 3'($urandom_range(0, 7));
    it.s2 = 3'($urandom_range(0, 7));
    it.s3 = 3'($urandom_range(0, 7));
    it.fv = 2'($urandom_range(0, 3));
    prev = last_hall[it.motor];
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      it.s1 = $urandom_range(0, 1) ? HALL_FWD[prev] : HALL_REV[prev];
      if (roll >= 6) it.s2 = it.s1;
      if ($urandom_range(0, 9) != 0) it.s3 = it.s2;
    end else if (roll < 80) begin
      it.kind = OP_EDGE;
    end else if (roll < 87) begin
      it.kind = OP_FLAGS;
    end else if (roll < 95) begin
      it.kind = OP_RESYNC;
      if ($urandom_range(0, 4) != 0) it.s1 = 3'($urandom_range(1, 6));
    end else begin
      it.kind = OP_NONE;
    end
    return it;
  endfunction

  function automatic string show(hall_result_t r);
    return $sformatf("motor %0d hall %0d drive %0d low %02h high %02h pos %0d err %0d",
                     r.motor, r.hall, r.drive, r.gate_low, r.gate_high,
                     $signed(r.position), r.errors);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TBL_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    comm_words[idx] = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_tables(input logic [TBL_W-1:0] w0, input logic [TBL_W-1:0] w1,
                             input logic [TBL_W-1:0] w2, input logic [TBL_W-1:0] w3);
    write_reg(CFG_M0_LOW, w0);
    write_reg(CFG_M0_HIGH, w1);
    write_reg(CFG_M1_LOW, w2);
    write_reg(CFG_M1_HIGH, w3);
  endtask

  function automatic logic [TBL_W-1:0] random_table();
    logic [15:0] upper;
    logic [31:0] lower;
    upper = 16'($urandom);
    lower = $urandom;
    return {upper, lower};
  endfunction

  task automatic send(input hall_item_t it, input logic typed, input hall_result_t typed_res);
    hall_result_t predicted;
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = {it.motor, it.kind};
    s_axis_tdata_i = {5'd0, it.fv, it.s3, it.s2, it.s1};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = commutate(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i = 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      observed.motor = m_axis_tuser_o[0];
      observed.drive = m_axis_tuser_o[1];
      observed.hall = m_axis_tdata_o[2:0];
      observed.gate_low = m_axis_tdata_o[8:3];
      observed.gate_high = m_axis_tdata_o[14:9];
      observed.position = m_axis_tdata_o[46:15];
      observed.errors = m_axis_tdata_o[48:47];
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", show(observed));
        mismatches++;
      end else begin
        wanted = pending_results.pop_front();
        if (observed !== wanted) begin
          if (mismatches < 10) begin
            $display("result mismatch: expected %s", show(wanted));
            $display("                 got      %s", show(observed));
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = '0;
    s_axis_tdata_i = '0;
    for (int i = 0; i < 4; i++) comm_words[i] = '0;
    for (int i = 0; i < 2; i++) begin
      last_hall[i] = '0;
      cur_hall[i] = '0;
      steps[i] = '0;
      err_flags[i] = '0;
      gate_mask[i] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle = 1'b1;
    recv_idle = 1'b1;
    load_tables('1, '1, '1, '1);
    for (int r = 0; r < NUM_ROWS; r++) begin
      send(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].res);
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      if (phase == 1) begin
        load_tables('0, '0, '0, '0);
      end else begin
        load_tables(random_table(), random_table(), random_table(), random_table());
      end
      send_idle = (phase <= 1);
      recv_idle = (phase == 0 || phase == 2);
      repeat (ITEMS_PER_PHASE) send(next_item(), 1'b0, NO_RESULT);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/hct_pkg.sv
rtl/hct_front.sv
rtl/hct_queue.sv
rtl/hct_back.sv
rtl/hall_commutation_tracker.sv
rtl/hct_checker.sv
tb/sv/testbench.sv
